### hdl/bhpq_pkg.sv
// bhpq_pkg: shared types and codes for the binary heap priority queue
// no dependencies
`default_nettype none
package bhpq_pkg;
  localparam int unsigned KeyW = 32;
  localparam int unsigned PayW = 32;
  localparam int unsigned OccW = 11;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;
endpackage
`default_nettype wire

### hdl/binary_heap_priority_queue.sv
// binary_heap_priority_queue: heap of key and payload words in one synchronous memory
// depends on bhpq_pkg; reset clears the entry count and order mode, not the memory
// insert sifts the new entry up one heap level at a time; a refused insert goes straight to output
// remove reads the root, then the last entry, then sifts it down level by level; empty goes straight to output
// one request at a time: in_stall stays high until the result word has been taken
// each heap level visited during a sift needs its own registered memory read
`default_nettype none
module binary_heap_priority_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    req_type_i,
  input  wire logic [31:0]             entry_key_i,
  input  wire logic [31:0]             entry_payload_i,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_data_i,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [31:0]                  out_key_o,
  output logic [31:0]                  out_payload_o,
  output logic [1:0]                   status_o,
  output logic [10:0]                  occupancy_o
);
  import bhpq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_UPRD  = 10'b0000000010,
    S_UPCMP = 10'b0000000100,
    S_UPWR  = 10'b0000001000,
    S_RMRD  = 10'b0000010000,
    S_RMLST = 10'b0000100000,
    S_DNL   = 10'b0001000000,
    S_DNR   = 10'b0010000000,
    S_DNCMP = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [KeyW+PayW-1:0] mem [CAPACITY];
  logic [KeyW+PayW-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [KeyW+PayW-1:0] mem_wd;

  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 mode_q;
  logic [AW-1:0]        pos_q, pos_d;
  logic [KeyW+PayW-1:0] cur_q, cur_d, lft_q, lft_d;
  logic                 rgt_ok_q, rgt_ok_d;
  logic [KeyW-1:0]      okey_q, okey_d;
  logic [PayW-1:0]      opay_q, opay_d;
  logic [1:0]           st_q, st_d;

  function automatic logic higher(input logic m, input logic [KeyW-1:0] a,
                                  input logic [KeyW-1:0] b);
    higher = m ? (a < b) : (a > b);
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  logic [CW:0]   lidx, ridx;
  logic [AW-1:0] par;
  logic [KeyW+PayW-1:0] best;
  logic [CW:0]   bidx;
  always_comb begin
    lidx = {{(CW+1-AW){1'b0}}, pos_q} * (CW+1)'(2) + (CW+1)'(1);
    ridx = lidx + (CW+1)'(1);
    par  = (pos_q - AW'(1)) >> 1;
    best = lft_q;
    bidx = lidx;
    if (rgt_ok_q && higher(mode_q, rdata_q[KeyW+PayW-1:PayW], lft_q[KeyW+PayW-1:PayW])) begin
      best = rdata_q;
      bidx = ridx;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pos_d = pos_q; cur_d = cur_q; lft_d = lft_q;
    rgt_ok_d = rgt_ok_q; okey_d = okey_q; opay_d = opay_q; st_d = st_q;
    mem_we = 1'b0; mem_wa = pos_q; mem_wd = cur_q; mem_ra = pos_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          okey_d = '0; opay_d = '0;
          if (req_type_i == REQ_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              st_d = ST_FULL; state_d = S_OUT;
            end else begin
              st_d = ST_INSERTED;
              cur_d = {entry_key_i, entry_payload_i};
              pos_d = cnt_q[AW-1:0];
              cnt_d = cnt_q + CW'(1);
              state_d = S_UPRD;
            end
          end else if (cnt_q == '0) begin
            st_d = ST_EMPTY; state_d = S_OUT;
          end else begin
            st_d = ST_REMOVED;
            cnt_d = cnt_q - CW'(1);
            state_d = S_RMRD;
          end
        end
      end
      S_UPRD: begin
        if (pos_q == '0) begin
          mem_we = 1'b1; state_d = S_OUT;
        end else begin
          mem_ra = par; state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (higher(mode_q, cur_q[KeyW+PayW-1:PayW], rdata_q[KeyW+PayW-1:PayW])) begin
          mem_we = 1'b1; mem_wd = rdata_q;
          pos_d = par; state_d = S_UPRD;
        end else begin
          mem_we = 1'b1; state_d = S_OUT;
        end
      end
      S_RMRD: begin
        mem_ra = '0; state_d = S_RMLST;
      end
      S_RMLST: begin
        mem_ra = cnt_q[AW-1:0];
        if (state_q == S_RMLST) begin
          okey_d = rdata_q[KeyW+PayW-1:PayW];
          opay_d = rdata_q[PayW-1:0];
        end
        pos_d = '0;
        state_d = S_UPWR;
      end
      S_UPWR: begin
        // root replacement now in rdata
        cur_d = rdata_q;
        state_d = S_DNL;
        if (cnt_q == '0) state_d = S_OUT;
      end
      S_DNL: begin
        if (lidx >= (CW+1)'(cnt_q)) begin
          mem_we = 1'b1; state_d = S_OUT;
        end else begin
          mem_ra = lidx[AW-1:0];
          rgt_ok_d = ridx < (CW+1)'(cnt_q);
          state_d = S_DNR;
        end
      end
      S_DNR: begin
        lft_d = rdata_q;
        mem_ra = rgt_ok_q ? ridx[AW-1:0] : lidx[AW-1:0];
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        if (higher(mode_q, best[KeyW+PayW-1:PayW], cur_q[KeyW+PayW-1:PayW])) begin
          mem_we = 1'b1; mem_wd = best;
          pos_d = bidx[AW-1:0]; state_d = S_DNL;
        end else begin
          mem_we = 1'b1; state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid && cfg_ready) mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; cur_q <= cur_d; lft_q <= lft_d; rgt_ok_q <= rgt_ok_d;
    okey_q <= okey_d; opay_q <= opay_d; st_q <= st_d;
  end

  assign in_stall      = (state_q != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = (state_q == S_OUT);
  assign out_key_o     = okey_q;
  assign out_payload_o = opay_q;
  assign status_o      = st_q;
  assign occupancy_o   = 11'(cnt_q);

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("count above capacity");
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_stall == 1'b0 && out_valid)) else $error("accept while result pending");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_OUT && $past(state_q) != S_IDLE) |-> $stable(cnt_q))
    else $error("count moved during sift");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status_o == ST_EMPTY) |-> (occupancy_o == '0 && out_key_o == '0))
    else $error("empty result not clean");
`endif
endmodule
`default_nettype wire

### dv/binary_heap_priority_queue_tb.sv
// binary_heap_priority_queue_tb: random and directed test of the heap priority queue
// depends on bhpq_pkg and binary_heap_priority_queue; results checked against a heap kept here
`timescale 1ns / 100ps
module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam int unsigned Depth = 1024;

  typedef struct packed {
    logic            req;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
  } request_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
    status_e         status;
    logic [OccW-1:0] occ;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type_i = REQ_INSERT;
  logic [31:0] entry_key_i = '0;
  logic [31:0] entry_payload_i = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_key_o;
  logic [31:0] out_payload_o;
  logic [1:0] status_o;
  logic [10:0] occupancy_o;

  binary_heap_priority_queue #(.CAPACITY(Depth)) uut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i, .entry_key_i, .entry_payload_i,
    .cfg_valid, .cfg_ready, .cfg_data_i, .out_valid, .out_stall, .out_key_o,
    .out_payload_o, .status_o, .occupancy_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  request_t    pending_q[$];
  response_t   expected_q[$];
  logic [31:0] heap_key[Depth];
  logic [31:0] heap_pay[Depth];
  int unsigned heap_count = 0;
  logic        smaller_first = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  function automatic bit outranks(logic [31:0] a, logic [31:0] b);
    return smaller_first ? (a < b) : (a > b);
  endfunction

  function automatic void swap_entries(int unsigned i, int unsigned j);
    logic [31:0] k, p;
    k = heap_key[i]; p = heap_pay[i];
    heap_key[i] = heap_key[j]; heap_pay[i] = heap_pay[j];
    heap_key[j] = k; heap_pay[j] = p;
  endfunction

  function automatic void predict_heap(request_t r);
    response_t   res;
    int unsigned pos, up, l, best;
    res = '0;
    if (r.req == REQ_INSERT) begin
      if (heap_count >= Depth) begin
        res.status = ST_FULL;
      end else begin
        heap_key[heap_count] = r.key;
        heap_pay[heap_count] = r.pay;
        pos = heap_count;
        heap_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!outranks(heap_key[pos], heap_key[up])) break;
          swap_entries(pos, up);
          pos = up;
        end
        res.status = ST_INSERTED;
      end
    end else if (heap_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.key = heap_key[0];
      res.pay = heap_pay[0];
      heap_count--;
      heap_key[0] = heap_key[heap_count];
      heap_pay[0] = heap_pay[heap_count];
      pos = 0;
      while (2 * pos + 1 < heap_count) begin
        l = 2 * pos + 1;
        best = l;
        if (l + 1 < heap_count && outranks(heap_key[l + 1], heap_key[l])) best = l + 1;
        if (!outranks(heap_key[best], heap_key[pos])) break;
        swap_entries(pos, best);
        pos = best;
      end
      res.status = ST_REMOVED;
    end
    res.occ = heap_count[OccW-1:0];
    expected_q.push_back(res);
  endfunction

  function automatic bit idle_roll();
    if (cycle_cnt >= 3000 && cycle_cnt < 9000) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // driver
  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni) begin
      if (in_valid && !in_stall)
        predict_heap('{req: req_type_i, key: entry_key_i, pay: entry_payload_i});
      if (!(in_valid && in_stall)) begin
        if (pending_q.size() > 0 && !idle_roll()) begin
          r = pending_q.pop_front();
          in_valid <= 1'b1;
          req_type_i <= r.req;
          entry_key_i <= r.key;
          entry_payload_i <= r.pay;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    response_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: key %h pay %h status %0d occ %0d",
                                     out_key_o, out_payload_o, status_o, occupancy_o);
        end else begin
          e = expected_q.pop_front();
          if (out_key_o !== e.key || out_payload_o !== e.pay || status_o !== e.status ||
              occupancy_o !== e.occ) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp key %h pay %h status %0d occ %0d, got %h %h %0d %0d",
                       e.key, e.pay, e.status, e.occ,
                       out_key_o, out_payload_o, status_o, occupancy_o);
          end
        end
      end
      out_stall <= idle_roll();
    end
  end

  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic req, logic [31:0] key, logic [31:0] pay);
    pending_q.push_back('{req: req, key: key, pay: pay});
  endtask

  task automatic add_random(int unsigned n, int unsigned insert_pct);
    repeat (n) add_item($urandom_range(99) < insert_pct ? REQ_INSERT : REQ_REMOVE,
                        rand_key(), $urandom);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_order(logic v);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    smaller_first = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // larger first after reset: empty remove, extremes, ties
    add_item(REQ_REMOVE, 32'h0, 32'h0);
    add_item(REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
    add_item(REQ_INSERT, 32'hFFFF_FFFF, 32'h0);
    add_item(REQ_INSERT, 32'h5, 32'h1);
    add_item(REQ_INSERT, 32'h5, 32'h2);
    add_item(REQ_INSERT, 32'h5, 32'h3);
    add_item(REQ_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    add_item(REQ_INSERT, 32'h8000_0000, 32'h5555_5555);
    repeat (8) add_item(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    write_order(1'b1);
    add_random(150, 60);
    wait_drained();

    write_order(1'b0);
    add_random(150, 40);
    wait_drained();

    // fill to capacity, refused inserts, then drain a little
    write_order(1'b1);
    repeat (Depth - heap_count) add_item(REQ_INSERT, rand_key(), $urandom);
    add_item(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(REQ_INSERT, 32'h0, 32'h0);
    add_random(40, 15);
    wait_drained();

    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
